/* src/jts_pkg.sv */
// Shared types, constants and helpers of the joint target smoother.
// Used by every module under src; depends on nothing else.
`default_nettype none

package jts_pkg;

    // Field widths.
    localparam int ANG_W      = 24;
    localparam int ALPHA_W    = 16;
    localparam int STEP_W     = 20;
    localparam int JOINT_W    = 4;
    localparam int NUM_JOINTS = 12;
    localparam int JIDX_W     = $clog2(NUM_JOINTS);
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    // Low-pass product: unsigned alpha times a signed difference one bit wider than an angle.
    localparam int DIFF_W = ANG_W + 1;
    localparam int PROD_W = ALPHA_W + 1 + DIFF_W;
    localparam int INC_W  = PROD_W - ALPHA_W;

    typedef logic signed [ANG_W-1:0] t_angle;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_STEP     = 4'd0,
        REG_LPF_ALPHA    = 4'd1,
        REG_LOW_ABDUCT   = 4'd2,
        REG_LOW_HIP      = 4'd3,
        REG_LOW_KNEE     = 4'd4,
        REG_HIGH_ABDUCT  = 4'd5,
        REG_HIGH_HIP     = 4'd6,
        REG_HIGH_KNEE    = 4'd7
    } t_cfg_reg;

    // Reset values of the registers.
    localparam logic [STEP_W-1:0]  RST_MAX_STEP    = STEP_W'(786);
    localparam logic [ALPHA_W-1:0] RST_LPF_ALPHA   = ALPHA_W'(1966);
    localparam t_angle             RST_LOW_ABDUCT  = t_angle'(-629146);
    localparam t_angle             RST_LOW_HIP     = t_angle'(-629146);
    localparam t_angle             RST_LOW_KNEE    = t_angle'(-1205862);
    localparam t_angle             RST_HIGH_ABDUCT = t_angle'(629146);
    localparam t_angle             RST_HIGH_HIP    = t_angle'(786432);
    localparam t_angle             RST_HIGH_KNEE   = t_angle'(-262144);

    // Joint types, taken from the joint number modulo three.
    typedef enum logic [1:0] {
        TYPE_ABDUCT = 2'd0,
        TYPE_HIP    = 2'd1,
        TYPE_KNEE   = 2'd2
    } t_joint_type;

    // Register file contents.
    typedef struct packed {
        logic [STEP_W-1:0]  max_step;
        logic [ALPHA_W-1:0] alpha;
        t_angle             low_abduct;
        t_angle             low_hip;
        t_angle             low_knee;
        t_angle             high_abduct;
        t_angle             high_hip;
        t_angle             high_knee;
    } t_cfg;

    // One input item as held in stage one.
    typedef struct packed {
        logic               preload;
        logic [JOINT_W-1:0] joint;
        t_angle             cmd;
        t_angle             stand;
        logic               allowed;
    } t_item;

    // Stage two result handed to the slew stage.
    typedef struct packed {
        logic [JOINT_W-1:0] joint;
        logic               in_range;
        logic               preload;
        t_angle             stand;
        t_angle             clamped;
        t_angle             lp_value;
    } t_lp_res;

    // One result item.
    typedef struct packed {
        logic [JOINT_W-1:0] joint;
        t_angle             filtered;
        t_angle             lowpass;
        logic               limited;
    } t_result;

    // Load and store-write strobes of the pipeline stages.
    typedef struct packed {
        logic ld2;
        logic wr2;
        logic ld3;
        logic wr3;
    } t_pipe_ctl;

    // Joint number modulo three, as a small table.
    function automatic t_joint_type joint_type(input logic [JOINT_W-1:0] joint);
        t_joint_type jt;
        case (joint)
            4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: jt = TYPE_ABDUCT;
            4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       jt = TYPE_HIP;
            default:                              jt = TYPE_KNEE;
        endcase
        return jt;
    endfunction

endpackage

`default_nettype wire

/* src/jts_cfg.sv */
// Configuration register file of the joint target smoother.
// Depends on jts_pkg for the register indexes and reset values.
`default_nettype none

module jts_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [jts_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [jts_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output jts_pkg::t_cfg                  o_cfg
);
    import jts_pkg::*;

    t_cfg r_cfg;

    // Register writes; indexes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_step    <= RST_MAX_STEP;
            r_cfg.alpha       <= RST_LPF_ALPHA;
            r_cfg.low_abduct  <= RST_LOW_ABDUCT;
            r_cfg.low_hip     <= RST_LOW_HIP;
            r_cfg.low_knee    <= RST_LOW_KNEE;
            r_cfg.high_abduct <= RST_HIGH_ABDUCT;
            r_cfg.high_hip    <= RST_HIGH_HIP;
            r_cfg.high_knee   <= RST_HIGH_KNEE;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_MAX_STEP:    r_cfg.max_step    <= i_cfg_wdata[STEP_W-1:0];
                REG_LPF_ALPHA:   r_cfg.alpha       <= i_cfg_wdata[ALPHA_W-1:0];
                REG_LOW_ABDUCT:  r_cfg.low_abduct  <= t_angle'(i_cfg_wdata[ANG_W-1:0]);
                REG_LOW_HIP:     r_cfg.low_hip     <= t_angle'(i_cfg_wdata[ANG_W-1:0]);
                REG_LOW_KNEE:    r_cfg.low_knee    <= t_angle'(i_cfg_wdata[ANG_W-1:0]);
                REG_HIGH_ABDUCT: r_cfg.high_abduct <= t_angle'(i_cfg_wdata[ANG_W-1:0]);
                REG_HIGH_HIP:    r_cfg.high_hip    <= t_angle'(i_cfg_wdata[ANG_W-1:0]);
                REG_HIGH_KNEE:   r_cfg.high_knee   <= t_angle'(i_cfg_wdata[ANG_W-1:0]);
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* src/jts_lowpass.sv */
// Low-pass stages of the joint target smoother: store read and multiply,
// then rounding add, store update and clamp. Depends on jts_pkg.
`default_nettype none

module jts_lowpass (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  jts_pkg::t_item     i_s1,
    input  jts_pkg::t_cfg      i_cfg,
    input  jts_pkg::t_pipe_ctl i_ctl,
    output jts_pkg::t_lp_res   o_s2
);
    import jts_pkg::*;

    typedef struct packed {
        logic [JOINT_W-1:0]       joint;
        logic                     in_range;
        logic                     preload;
        logic                     allowed;
        logic                     loaded;
        t_angle                   cmd;
        t_angle                   stand;
        t_angle                   lp_old;
        t_angle                   low;
        t_angle                   high;
        logic signed [PROD_W-1:0] prod;
    } t_s2;

    t_angle r_lp     [NUM_JOINTS];
    logic   r_loaded [NUM_JOINTS];
    t_s2    r_s2;

    logic                     s1_in_range;
    logic [JIDX_W-1:0]        s1_idx;
    t_angle                   s1_lp;
    logic                     s1_loaded;
    logic signed [DIFF_W-1:0] s1_diff;
    logic signed [PROD_W-1:0] s1_prod;
    t_angle                   s1_low;
    t_angle                   s1_high;

    logic [JIDX_W-1:0]        s2_idx;
    logic signed [INC_W-1:0]  s2_sum;
    t_angle                   n_lp;
    logic                     n_loaded;
    t_angle                   s2_target;
    t_angle                   s2_clamped;

    // Stage one: store read, difference and alpha multiply.
    always_comb begin
        s1_in_range = (i_s1.joint < JOINT_W'(NUM_JOINTS));
        s1_idx      = i_s1.joint[JIDX_W-1:0];
        s1_lp       = s1_in_range ? r_lp[s1_idx] : '0;
        s1_loaded   = s1_in_range ? r_loaded[s1_idx] : 1'b0;
        s1_diff     = $signed({i_s1.cmd[ANG_W-1], i_s1.cmd}) - $signed({s1_lp[ANG_W-1], s1_lp});
        s1_prod     = $signed({1'b0, i_cfg.alpha}) * s1_diff;
    end

    // Stage one: limits of this joint's type.
    always_comb begin
        case (joint_type(i_s1.joint))
            TYPE_ABDUCT: begin
                s1_low  = i_cfg.low_abduct;
                s1_high = i_cfg.high_abduct;
            end
            TYPE_HIP: begin
                s1_low  = i_cfg.low_hip;
                s1_high = i_cfg.high_hip;
            end
            default: begin
                s1_low  = i_cfg.low_knee;
                s1_high = i_cfg.high_knee;
            end
        endcase
    end

    // Stage two register.
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld2) begin
            r_s2.joint    <= i_s1.joint;
            r_s2.in_range <= s1_in_range;
            r_s2.preload  <= i_s1.preload;
            r_s2.allowed  <= i_s1.allowed;
            r_s2.loaded   <= s1_loaded;
            r_s2.cmd      <= i_s1.cmd;
            r_s2.stand    <= i_s1.stand;
            r_s2.lp_old   <= s1_lp;
            r_s2.low      <= s1_low;
            r_s2.high     <= s1_high;
            r_s2.prod     <= s1_prod;
        end
    end

    // Stage two: floor of the product over 2^16 plus the rounding bit, added to the old state.
    always_comb begin
        s2_idx = r_s2.joint[JIDX_W-1:0];
        s2_sum = $signed({{(INC_W-ANG_W){r_s2.lp_old[ANG_W-1]}}, r_s2.lp_old})
               + r_s2.prod[PROD_W-1:ALPHA_W]
               + $signed({{(INC_W-1){1'b0}}, r_s2.prod[ALPHA_W-1]});
    end

    // Stage two: next low-pass state and loaded flag.
    always_comb begin
        if (r_s2.preload) begin
            n_lp     = r_s2.stand;
            n_loaded = 1'b0;
        end else if (r_s2.allowed) begin
            n_lp     = r_s2.loaded ? t_angle'(s2_sum[ANG_W-1:0]) : r_s2.cmd;
            n_loaded = 1'b1;
        end else begin
            n_lp     = r_s2.lp_old;
            n_loaded = r_s2.loaded;
        end
    end

    // Stage two: target choice and clamp; the low limit wins only below it.
    always_comb begin
        s2_target = r_s2.allowed ? n_lp : r_s2.stand;
        if ($signed(s2_target) < $signed(r_s2.low)) begin
            s2_clamped = r_s2.low;
        end else if ($signed(s2_target) > $signed(r_s2.high)) begin
            s2_clamped = r_s2.high;
        end else begin
            s2_clamped = s2_target;
        end
    end

    // Low-pass store, written as the item leaves stage two.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_JOINTS; k++) begin
                r_lp[k]     <= '0;
                r_loaded[k] <= 1'b0;
            end
        end else if (i_ctl.wr2 && r_s2.in_range) begin
            r_lp[s2_idx]     <= n_lp;
            r_loaded[s2_idx] <= n_loaded;
        end
    end

    always_comb begin
        o_s2.joint    = r_s2.joint;
        o_s2.in_range = r_s2.in_range;
        o_s2.preload  = r_s2.preload;
        o_s2.stand    = r_s2.stand;
        o_s2.clamped  = s2_clamped;
        o_s2.lp_value = n_lp;
    end

endmodule

`default_nettype wire

/* src/jts_slew.sv */
// Slew stage of the joint target smoother: step limit against the slewed
// store and the result fields. Depends on jts_pkg.
`default_nettype none

module jts_slew (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  jts_pkg::t_lp_res          i_s2,
    input  logic [jts_pkg::STEP_W-1:0] i_max_step,
    input  jts_pkg::t_pipe_ctl        i_ctl,
    output jts_pkg::t_result          o_res
);
    import jts_pkg::*;

    t_angle  r_sl [NUM_JOINTS];
    t_lp_res r_s3;

    logic [JIDX_W-1:0]        s3_idx;
    t_angle                   s3_old;
    logic signed [DIFF_W-1:0] s3_delta;
    logic signed [DIFF_W-1:0] s3_step;
    logic                     s3_up;
    logic                     s3_dn;
    t_angle                   n_sl;
    logic                     s3_limited;

    // Stage three register.
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld3) begin
            r_s3 <= i_s2;
        end
    end

    // Difference to the slewed store and the cut to the step size.
    always_comb begin
        s3_idx   = r_s3.joint[JIDX_W-1:0];
        s3_old   = r_s3.in_range ? r_sl[s3_idx] : '0;
        s3_delta = $signed({r_s3.clamped[ANG_W-1], r_s3.clamped})
                 - $signed({s3_old[ANG_W-1], s3_old});
        s3_step  = $signed({{(DIFF_W-STEP_W){1'b0}}, i_max_step});
        s3_up    = (s3_delta > s3_step);
        s3_dn    = (s3_delta < -s3_step);
    end

    // Next slewed value; a preload sets it to the stand angle as is.
    always_comb begin
        if (r_s3.preload) begin
            n_sl       = r_s3.stand;
            s3_limited = 1'b0;
        end else if (s3_up) begin
            n_sl       = s3_old + s3_step[ANG_W-1:0];
            s3_limited = 1'b1;
        end else if (s3_dn) begin
            n_sl       = s3_old - s3_step[ANG_W-1:0];
            s3_limited = 1'b1;
        end else begin
            n_sl       = r_s3.clamped;
            s3_limited = 1'b0;
        end
    end

    // Slewed store, written as the item leaves stage three.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_JOINTS; k++) begin
                r_sl[k] <= '0;
            end
        end else if (i_ctl.wr3 && r_s3.in_range) begin
            r_sl[s3_idx] <= n_sl;
        end
    end

    // Result fields; a joint number out of range gives zeros.
    always_comb begin
        o_res.joint = r_s3.joint;
        if (r_s3.in_range) begin
            o_res.filtered = n_sl;
            o_res.lowpass  = r_s3.lp_value;
            o_res.limited  = s3_limited;
        end else begin
            o_res.filtered = '0;
            o_res.lowpass  = '0;
            o_res.limited  = 1'b0;
        end
    end

endmodule

`default_nettype wire

/* src/joint_target_smoother.sv */
// Top level of the joint target smoother: input stage, pipeline control and
// output register. Depends on jts_pkg, jts_cfg, jts_lowpass and jts_slew.

// The block takes one joint update per clock unless stalled and returns one
// result per item, in order: stage one reads the low-pass store and multiplies
// by alpha, stage two rounds, updates the low-pass store and clamps to the
// joint type's limits, stage three applies the step limit against the slewed
// store, and the output register holds the result. The low-pass
// read-modify-write spans the multiply register, so an item for the same joint
// as the item directly ahead of it waits in stage one until that item leaves
// stage two; items on different joints flow at one per cycle when not stalled.
// Stall on the output side backs up stage by stage and drops nothing.
// Configuration writes take effect at once and must be made while no item is
// in flight.
`default_nettype none

module joint_target_smoother (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [jts_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [jts_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_action,
    input  logic [jts_pkg::JOINT_W-1:0]    i_joint_index,
    input  logic signed [jts_pkg::ANG_W-1:0] i_command_target,
    input  logic signed [jts_pkg::ANG_W-1:0] i_stand_target,
    input  logic                           i_policy_allowed,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [jts_pkg::JOINT_W-1:0]    o_joint_out,
    output logic signed [jts_pkg::ANG_W-1:0] o_filtered_target,
    output logic signed [jts_pkg::ANG_W-1:0] o_lowpass_value,
    output logic                           o_slew_limited
);
    import jts_pkg::*;

    t_cfg      cfg;
    t_item     r_s1;
    logic      r_v1;
    logic      r_v2;
    logic      r_v3;
    logic      r_vo;
    t_result   r_out;
    t_lp_res   s2_res;
    t_result   s3_res;
    t_pipe_ctl ctl;

    logic in_xfer;
    logic hazard;
    logic adv1;
    logic adv2;
    logic adv3;

    jts_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // Stage advance: next stage empty or moving, and no hazard for stage one.
    always_comb begin
        adv3    = r_v3 && (!r_vo || i_out_ready);
        adv2    = r_v2 && (!r_v3 || adv3);
        hazard  = r_v2 && (r_s1.joint == s2_res.joint);
        adv1    = r_v1 && !hazard && (!r_v2 || adv2);
        in_xfer = i_in_valid && o_in_ready;
        ctl.ld2 = adv1;
        ctl.wr2 = adv2;
        ctl.ld3 = adv2;
        ctl.wr3 = adv3;
    end

    assign o_in_ready = !r_v1 || adv1;

    // Valid bits of the stages and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_v1 <= 1'b1;
            end else if (adv1) begin
                r_v1 <= 1'b0;
            end
            if (adv1) begin
                r_v2 <= 1'b1;
            end else if (adv2) begin
                r_v2 <= 1'b0;
            end
            if (adv2) begin
                r_v3 <= 1'b1;
            end else if (adv3) begin
                r_v3 <= 1'b0;
            end
            if (adv3) begin
                r_vo <= 1'b1;
            end else if (i_out_ready) begin
                r_vo <= 1'b0;
            end
        end
    end

    // Stage one input register.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1.preload <= i_action;
            r_s1.joint   <= i_joint_index;
            r_s1.cmd     <= i_command_target;
            r_s1.stand   <= i_stand_target;
            r_s1.allowed <= i_policy_allowed;
        end
    end

    jts_lowpass u_lowpass (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s1    (r_s1),
        .i_cfg   (cfg),
        .i_ctl   (ctl),
        .o_s2    (s2_res)
    );

    jts_slew u_slew (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s2       (s2_res),
        .i_max_step (cfg.max_step),
        .i_ctl      (ctl),
        .o_res      (s3_res)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_out <= s3_res;
        end
    end

    assign o_out_valid       = r_vo;
    assign o_joint_out       = r_out.joint;
    assign o_filtered_target = r_out.filtered;
    assign o_lowpass_value   = r_out.lowpass;
    assign o_slew_limited    = r_out.limited;

    // An item never leaves stage one while stage two holds the same joint.
    a_no_lp_overtake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && (r_s1.joint == s2_res.joint)) |-> !ctl.ld2)
        else $error("stage one advanced over a pending low-pass write");

    // A result for a joint out of range carries zero fields.
    a_bad_joint_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_joint_out >= JOINT_W'(NUM_JOINTS))) |->
        (o_filtered_target == '0 && o_lowpass_value == '0 && !o_slew_limited))
        else $error("out of range joint gave nonzero result fields");

    // Stage three, when it holds an item and cannot move, keeps it.
    a_stage3_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !adv3) |=> r_v3)
        else $error("stage three lost an item under stall");

endmodule

`default_nettype wire
